// ===== rtl/wavhp_pkg.sv =====
// Package for the WAV header parser: transaction structs, status codes,
// header byte offsets, tag words and the divider control structs.
// No dependencies.
`default_nettype none

package wavhp_pkg;

    typedef struct packed {
        logic [7:0] header_byte;
        logic       start_req;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  status;
        logic [15:0] channels;
        logic [31:0] sample_rate;
        logic [31:0] avg_bytes_sec;
        logic [15:0] block_align;
        logic [15:0] sample_bits;
        logic [31:0] riff_size;
        logic [31:0] data_size;
        logic [31:0] total_samples;
    } t_out_item;

    // Status codes
    localparam logic [3:0] ST_OK         = 4'd0;
    localparam logic [3:0] ST_RIFF       = 4'd1;
    localparam logic [3:0] ST_WAVE       = 4'd2;
    localparam logic [3:0] ST_FMT_ID     = 4'd3;
    localparam logic [3:0] ST_FMT_SIZE   = 4'd4;
    localparam logic [3:0] ST_NOT_PCM    = 4'd5;
    localparam logic [3:0] ST_CHANNELS   = 4'd6;
    localparam logic [3:0] ST_ALIGN      = 4'd7;
    localparam logic [3:0] ST_DATA_ID    = 4'd8;
    localparam logic [3:0] ST_ZERO_ALIGN = 4'd9;

    // Offset of the last byte of each header field
    localparam logic [5:0] IDX_RIFF_TAG   = 6'd3;
    localparam logic [5:0] IDX_RIFF_SIZE  = 6'd7;
    localparam logic [5:0] IDX_WAVE_TAG   = 6'd11;
    localparam logic [5:0] IDX_FMT_TAG    = 6'd15;
    localparam logic [5:0] IDX_FMT_SIZE   = 6'd19;
    localparam logic [5:0] IDX_AUDIO_FMT  = 6'd21;
    localparam logic [5:0] IDX_CHANNELS   = 6'd23;
    localparam logic [5:0] IDX_RATE       = 6'd27;
    localparam logic [5:0] IDX_AVG_RATE   = 6'd31;
    localparam logic [5:0] IDX_ALIGN      = 6'd33;
    localparam logic [5:0] IDX_BITS       = 6'd35;
    localparam logic [5:0] IDX_DATA_TAG   = 6'd39;
    localparam logic [5:0] IDX_DATA_SIZE  = 6'd43;

    // Little-endian tag words
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [31:0] FMT_CHUNK_SIZE = 32'd16;
    localparam logic [15:0] FMT_PCM        = 16'd1;
    localparam logic [15:0] CH_MONO        = 16'd1;
    localparam logic [15:0] CH_STEREO      = 16'd2;

    // Divider: 32-bit dividend, 16-bit divisor, one quotient bit per cycle
    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = 5;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [15:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        busy;
        logic [31:0] quotient;
    } t_div_rsp;

endpackage

`default_nettype wire

// ===== rtl/wavhp_div.sv =====
// Restoring divider for the WAV header parser: 32-bit by 16-bit unsigned,
// one quotient bit per cycle. Depends on wavhp_pkg.
`default_nettype none

module wavhp_div (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire wavhp_pkg::t_div_req i_req,
    output wavhp_pkg::t_div_rsp      o_rsp
);

    logic                            r_busy;
    logic [wavhp_pkg::DIV_CNT_W-1:0] r_count;
    logic [31:0]                     r_quo;
    logic [15:0]                     r_rem;
    logic [15:0]                     r_divisor;

    logic [16:0] rem_shift;
    logic [17:0] diff;

    // One restoring step: shift in the next dividend bit, try a subtract
    always_comb begin
        rem_shift = {r_rem, r_quo[31]};
        diff      = {1'b0, rem_shift} - {2'b00, r_divisor};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_count <= '0;
        end else if (i_req.start) begin
            r_busy    <= 1'b1;
            r_count   <= '0;
            r_quo     <= i_req.dividend;
            r_rem     <= '0;
            r_divisor <= i_req.divisor;
        end else if (r_busy) begin
            if (!diff[17]) begin
                r_rem <= diff[15:0];
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= rem_shift[15:0];
                r_quo <= {r_quo[30:0], 1'b0};
            end
            r_count <= r_count + wavhp_pkg::DIV_CNT_W'(1);
            if (r_count == wavhp_pkg::DIV_CNT_W'(wavhp_pkg::DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.quotient = r_quo;

endmodule

`default_nettype wire

// ===== rtl/wav_header_parser_top.sv =====
// Top level of the WAV header parser: byte sequencer, field registers,
// header checks and result register. Depends on wavhp_pkg and wavhp_div.
//
//   Channel  Direction  Handshake          Payload
//   -------  ---------  -----------------  --------------------------
//   input    in         i_valid / o_stall  i_data (t_in_item), 1 byte
//   result   out        o_valid / i_stall  o_data (t_out_item)
//
// Header bytes are accepted back to back unless the input is stalled. After
// byte 44 of a good header the divider finds the sample count one quotient
// bit at a time; the result is then loaded once the output slot is free.
// Synchronous active-low reset leaves the parser waiting for a start byte.
// Input is stalled while the divider runs and while a waiting result
// cannot drain in the same cycle.
`default_nettype none

module wav_header_parser_top (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire wavhp_pkg::t_in_item i_data,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output wavhp_pkg::t_out_item     o_data
);

    // Sequencer and header field registers
    logic        r_finished;
    logic        r_dividing;
    logic [5:0]  r_byte_index;
    logic [31:0] r_word;
    logic [15:0] r_channels;
    logic [31:0] r_rate;
    logic [31:0] r_avg_rate;
    logic [15:0] r_align;
    logic [15:0] r_bits;
    logic [31:0] r_riff_size;
    logic [31:0] r_data_size;

    logic        n_finished;
    logic [5:0]  n_byte_index;
    logic [31:0] n_word;
    logic [15:0] n_channels;
    logic [31:0] n_rate;
    logic [31:0] n_avg_rate;
    logic [15:0] n_align;
    logic [15:0] n_bits;
    logic [31:0] n_riff_size;
    logic [31:0] n_data_size;
    logic        n_emit;
    logic [3:0]  n_status;
    logic        n_div_go;

    // Result register
    logic                 r_out_valid;
    wavhp_pkg::t_out_item r_out;

    wavhp_pkg::t_div_req div_req;
    wavhp_pkg::t_div_rsp div_rsp;

    logic        in_accept;
    logic        out_free;
    logic        div_take;
    logic [5:0]  idx;
    logic [15:0] half;
    logic [16:0] frame_bits;

    // Output slot is free now or drains at this edge
    assign out_free  = !r_out_valid || !i_stall;
    assign o_stall   = r_dividing || !out_free;
    assign in_accept = i_valid && !o_stall;
    assign div_take  = r_dividing && !div_rsp.busy && out_free;

    always_comb begin
        n_finished   = r_finished;
        n_byte_index = r_byte_index;
        n_word       = r_word;
        n_channels   = r_channels;
        n_rate       = r_rate;
        n_avg_rate   = r_avg_rate;
        n_align      = r_align;
        n_bits       = r_bits;
        n_riff_size  = r_riff_size;
        n_data_size  = r_data_size;
        n_emit       = 1'b0;
        n_status     = wavhp_pkg::ST_OK;
        n_div_go     = 1'b0;
        idx          = '0;
        half         = '0;
        frame_bits   = '0;

        if (in_accept) begin
            // A start byte drops any header in progress and begins a new one
            if (i_data.start_req) begin
                n_finished   = 1'b0;
                n_byte_index = '0;
                n_word       = '0;
                n_channels   = '0;
                n_rate       = '0;
                n_avg_rate   = '0;
                n_align      = '0;
                n_bits       = '0;
                n_riff_size  = '0;
                n_data_size  = '0;
            end

            if (!n_finished) begin
                n_word       = {i_data.header_byte, n_word[31:8]};
                half         = n_word[31:16];
                idx          = n_byte_index;
                n_byte_index = idx + 6'd1;

                unique case (idx)
                    wavhp_pkg::IDX_RIFF_TAG: begin
                        if (n_word != wavhp_pkg::TAG_RIFF) begin
                            n_emit   = 1'b1;
                            n_status = wavhp_pkg::ST_RIFF;
                        end
                    end
                    wavhp_pkg::IDX_RIFF_SIZE: begin
                        n_riff_size = n_word;
                    end
                    wavhp_pkg::IDX_WAVE_TAG: begin
                        if (n_word != wavhp_pkg::TAG_WAVE) begin
                            n_emit   = 1'b1;
                            n_status = wavhp_pkg::ST_WAVE;
                        end
                    end
                    wavhp_pkg::IDX_FMT_TAG: begin
                        if (n_word != wavhp_pkg::TAG_FMT) begin
                            n_emit   = 1'b1;
                            n_status = wavhp_pkg::ST_FMT_ID;
                        end
                    end
                    wavhp_pkg::IDX_FMT_SIZE: begin
                        if (n_word != wavhp_pkg::FMT_CHUNK_SIZE) begin
                            n_emit   = 1'b1;
                            n_status = wavhp_pkg::ST_FMT_SIZE;
                        end
                    end
                    wavhp_pkg::IDX_AUDIO_FMT: begin
                        if (half != wavhp_pkg::FMT_PCM) begin
                            n_emit   = 1'b1;
                            n_status = wavhp_pkg::ST_NOT_PCM;
                        end
                    end
                    wavhp_pkg::IDX_CHANNELS: begin
                        n_channels = half;
                        if (half != wavhp_pkg::CH_MONO && half != wavhp_pkg::CH_STEREO) begin
                            n_emit   = 1'b1;
                            n_status = wavhp_pkg::ST_CHANNELS;
                        end
                    end
                    wavhp_pkg::IDX_RATE: begin
                        n_rate = n_word;
                    end
                    wavhp_pkg::IDX_AVG_RATE: begin
                        n_avg_rate = n_word;
                    end
                    wavhp_pkg::IDX_ALIGN: begin
                        n_align = half;
                    end
                    wavhp_pkg::IDX_BITS: begin
                        n_bits = half;
                        // Channels is already known to be one or two here
                        frame_bits = (n_channels == wavhp_pkg::CH_STEREO) ?
                                     {half, 1'b0} : {1'b0, half};
                        if (n_align != {2'b00, frame_bits[16:3]}) begin
                            n_emit   = 1'b1;
                            n_status = wavhp_pkg::ST_ALIGN;
                        end
                    end
                    wavhp_pkg::IDX_DATA_TAG: begin
                        if (n_word != wavhp_pkg::TAG_DATA) begin
                            n_emit   = 1'b1;
                            n_status = wavhp_pkg::ST_DATA_ID;
                        end
                    end
                    wavhp_pkg::IDX_DATA_SIZE: begin
                        n_data_size = n_word;
                        n_finished  = 1'b1;
                        if (n_align == '0) begin
                            n_emit   = 1'b1;
                            n_status = wavhp_pkg::ST_ZERO_ALIGN;
                        end else begin
                            n_div_go = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase

                if (n_emit) begin
                    n_finished = 1'b1;
                end
            end
        end
    end

    assign div_req.start    = n_div_go;
    assign div_req.dividend = n_data_size;
    assign div_req.divisor  = n_align;

    wavhp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_finished   <= 1'b1;
            r_dividing   <= 1'b0;
            r_byte_index <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_finished   <= n_finished;
            r_byte_index <= n_byte_index;

            // Load a new result, else drop the old one once taken
            if (n_emit || div_take) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (n_div_go) begin
                r_dividing <= 1'b1;
            end else if (div_take) begin
                r_dividing <= 1'b0;
            end
        end
    end

    // Field and result payload: no reset needed
    always_ff @(posedge i_clk) begin
        r_word      <= n_word;
        r_channels  <= n_channels;
        r_rate      <= n_rate;
        r_avg_rate  <= n_avg_rate;
        r_align     <= n_align;
        r_bits      <= n_bits;
        r_riff_size <= n_riff_size;
        r_data_size <= n_data_size;

        if (n_emit) begin
            r_out.status        <= n_status;
            r_out.channels      <= n_channels;
            r_out.sample_rate   <= n_rate;
            r_out.avg_bytes_sec <= n_avg_rate;
            r_out.block_align   <= n_align;
            r_out.sample_bits   <= n_bits;
            r_out.riff_size     <= n_riff_size;
            r_out.data_size     <= n_data_size;
            r_out.total_samples <= '0;
        end else if (div_take) begin
            r_out.status        <= wavhp_pkg::ST_OK;
            r_out.channels      <= r_channels;
            r_out.sample_rate   <= r_rate;
            r_out.avg_bytes_sec <= r_avg_rate;
            r_out.block_align   <= r_align;
            r_out.sample_bits   <= r_bits;
            r_out.riff_size     <= r_riff_size;
            r_out.data_size     <= r_data_size;
            r_out.total_samples <= div_rsp.quotient;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

`default_nettype wire

// ===== rtl/wavhp_checker.sv =====
// Port-level checks for the WAV header parser, bound to the top level.
// Depends on wavhp_pkg and wav_header_parser_top.
`default_nettype none

module wavhp_checker (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_valid,
    input wire logic                 o_stall,
    input wire wavhp_pkg::t_in_item  i_data,
    input wire logic                 o_valid,
    input wire logic                 i_stall,
    input wire wavhp_pkg::t_out_item o_data
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled result changed");

    // Failed headers report no sample count
    a_err_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status != wavhp_pkg::ST_OK |-> o_data.total_samples == '0)
        else $error("sample count on failed header");

    // A good header has a nonzero frame size
    a_ok_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status == wavhp_pkg::ST_OK |-> o_data.block_align != '0)
        else $error("good header with zero block align");

    // Zero-align status only with a zero frame size
    a_zero_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status == wavhp_pkg::ST_ZERO_ALIGN |-> o_data.block_align == '0)
        else $error("zero-align status with nonzero block align");

    // A good header carries one or two channels
    a_ok_channels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status == wavhp_pkg::ST_OK |->
        o_data.channels == wavhp_pkg::CH_MONO || o_data.channels == wavhp_pkg::CH_STEREO)
        else $error("good header with bad channel count");

endmodule

bind wav_header_parser_top wavhp_checker u_wavhp_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for wav_header_parser_top: queues RIFF/WAVE header bytes,
// predicts each result from the byte stream and checks every result transaction.
// Depends on wavhp_pkg and the parser RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int QUIET_LIMIT = 4000;  // cycles with no transaction on either channel
    localparam int DRAIN_CYCLES = 48;   // divider run plus result load, with margin
    localparam int TARGET_BYTES = 1900;

    // Ways to spoil a header; channel and align faults come in through the field values
    typedef enum int {
        FLT_NONE, FLT_RIFF, FLT_WAVE, FLT_FMT_ID, FLT_FMT_SIZE,
        FLT_FORMAT, FLT_CHANNELS, FLT_ALIGN, FLT_DATA_ID
    } t_header_fault;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    wavhp_pkg::t_in_item  i_data;
    logic                 o_valid;
    logic                 i_stall;
    wavhp_pkg::t_out_item o_data;

    wav_header_parser_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    // Byte stream still to be sent, and parse results still to arrive
    wavhp_pkg::t_in_item  header_bytes_q[$];
    wavhp_pkg::t_out_item header_results_q[$];

    int unsigned total_bytes = 0;
    int unsigned bytes_sent = 0;
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;
    int unsigned send_idle_pct = 19;
    int unsigned recv_idle_pct = 81;

    // Shadow parser state, cleared as after reset: waiting for a start byte
    logic [5:0]  p_pos      = '0;
    logic        p_done     = 1'b1;
    logic [31:0] p_shift    = '0;
    logic [15:0] p_channels = '0;
    logic [31:0] p_rate     = '0;
    logic [31:0] p_brate    = '0;
    logic [15:0] p_align    = '0;
    logic [15:0] p_bits     = '0;
    logic [31:0] p_riff_sz  = '0;
    logic [31:0] p_dsize    = '0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Advance the shadow parser by one accepted byte; queue a result when the
    // header completes or fails its first check.
    function automatic void predict_header_byte(input wavhp_pkg::t_in_item it);
        wavhp_pkg::t_out_item res;
        logic [5:0]           pos;
        logic [15:0]          upper;
        logic                 has_result;
        logic [3:0]           code;
        if (it.start_req) begin
            p_pos = '0;
            p_shift = '0;
            p_channels = '0;
            p_rate = '0;
            p_brate = '0;
            p_align = '0;
            p_bits = '0;
            p_riff_sz = '0;
            p_dsize = '0;
            p_done = 1'b0;
        end
        if (p_done) return;
        p_shift = {it.header_byte, p_shift[31:8]};
        upper = p_shift[31:16];
        pos = p_pos;
        p_pos = p_pos + 6'd1;
        has_result = 1'b0;
        code = wavhp_pkg::ST_OK;
        case (pos)
            wavhp_pkg::IDX_RIFF_TAG: if (p_shift != wavhp_pkg::TAG_RIFF) begin
                has_result = 1'b1;
                code = wavhp_pkg::ST_RIFF;
            end
            wavhp_pkg::IDX_RIFF_SIZE: p_riff_sz = p_shift;
            wavhp_pkg::IDX_WAVE_TAG: if (p_shift != wavhp_pkg::TAG_WAVE) begin
                has_result = 1'b1;
                code = wavhp_pkg::ST_WAVE;
            end
            wavhp_pkg::IDX_FMT_TAG: if (p_shift != wavhp_pkg::TAG_FMT) begin
                has_result = 1'b1;
                code = wavhp_pkg::ST_FMT_ID;
            end
            wavhp_pkg::IDX_FMT_SIZE: if (p_shift != wavhp_pkg::FMT_CHUNK_SIZE) begin
                has_result = 1'b1;
                code = wavhp_pkg::ST_FMT_SIZE;
            end
            wavhp_pkg::IDX_AUDIO_FMT: if (upper != wavhp_pkg::FMT_PCM) begin
                has_result = 1'b1;
                code = wavhp_pkg::ST_NOT_PCM;
            end
            wavhp_pkg::IDX_CHANNELS: begin
                p_channels = upper;
                if (upper != wavhp_pkg::CH_MONO && upper != wavhp_pkg::CH_STEREO) begin
                    has_result = 1'b1;
                    code = wavhp_pkg::ST_CHANNELS;
                end
            end
            wavhp_pkg::IDX_RATE: p_rate = p_shift;
            wavhp_pkg::IDX_AVG_RATE: p_brate = p_shift;
            wavhp_pkg::IDX_ALIGN: p_align = upper;
            wavhp_pkg::IDX_BITS: begin
                p_bits = upper;
                if ({16'd0, p_align} !=
                    (({16'd0, p_channels} * {16'd0, p_bits}) >> 3)) begin
                    has_result = 1'b1;
                    code = wavhp_pkg::ST_ALIGN;
                end
            end
            wavhp_pkg::IDX_DATA_TAG: if (p_shift != wavhp_pkg::TAG_DATA) begin
                has_result = 1'b1;
                code = wavhp_pkg::ST_DATA_ID;
            end
            wavhp_pkg::IDX_DATA_SIZE: begin
                p_dsize = p_shift;
                has_result = 1'b1;
                code = (p_align == 16'd0) ? wavhp_pkg::ST_ZERO_ALIGN : wavhp_pkg::ST_OK;
            end
            default: ;
        endcase
        if (has_result) begin
            res.status        = code;
            res.channels      = p_channels;
            res.sample_rate   = p_rate;
            res.avg_bytes_sec = p_brate;
            res.block_align   = p_align;
            res.sample_bits   = p_bits;
            res.riff_size     = p_riff_sz;
            res.data_size     = p_dsize;
            // Divide only on a clean header; a zero align never gets here with ST_OK
            res.total_samples = (code == wavhp_pkg::ST_OK) ?
                                p_dsize / {16'd0, p_align} : 32'd0;
            header_results_q.push_back(res);
            p_done = 1'b1;
        end
    endfunction

    function automatic logic [31:0] nonzero_mask();
        logic [31:0] m;
        if ($urandom_range(1) == 0) begin
            m = 32'd1 << $urandom_range(31);
        end else begin
            m = $urandom();
            if (m == 32'd0) m = 32'd1;
        end
        return m;
    endfunction

    // Lay out one 44-byte header as eleven little-endian words, spoil it as
    // asked, and queue the first send_len bytes plus trail random bytes with no start flag.
    task automatic queue_header(input t_header_fault fault, input logic [15:0] ch,
                                input logic [15:0] bits, input logic [15:0] align,
                                input logic [31:0] riff_sz, input logic [31:0] rate,
                                input logic [31:0] brate, input logic [31:0] dsize,
                                input int send_len, input int trail);
        logic [31:0]         w [11];
        logic [15:0]         fmt_mask;
        wavhp_pkg::t_in_item it;
        w[0]  = wavhp_pkg::TAG_RIFF;
        w[1]  = riff_sz;
        w[2]  = wavhp_pkg::TAG_WAVE;
        w[3]  = wavhp_pkg::TAG_FMT;
        w[4]  = wavhp_pkg::FMT_CHUNK_SIZE;
        w[5]  = {ch, wavhp_pkg::FMT_PCM};
        w[6]  = rate;
        w[7]  = brate;
        w[8]  = {bits, align};
        w[9]  = wavhp_pkg::TAG_DATA;
        w[10] = dsize;
        fmt_mask = 16'(nonzero_mask() >> 16);
        if (fmt_mask == 16'd0) fmt_mask = 16'd1;
        case (fault)
            FLT_RIFF:     w[0] ^= nonzero_mask();
            FLT_WAVE:     w[2] ^= nonzero_mask();
            FLT_FMT_ID:   w[3] ^= nonzero_mask();
            FLT_FMT_SIZE: w[4] ^= nonzero_mask();
            FLT_FORMAT:   w[5][15:0] ^= fmt_mask;
            FLT_DATA_ID:  w[9] ^= nonzero_mask();
            default: ;
        endcase
        for (int i = 0; i < send_len; i++) begin
            it.header_byte = w[i / 4][8 * (i % 4) +: 8];
            it.start_req = (i == 0);
            header_bytes_q.push_back(it);
        end
        for (int i = 0; i < trail; i++) begin
            it.header_byte = 8'($urandom_range(255));
            it.start_req = 1'b0;
            header_bytes_q.push_back(it);
        end
        total_bytes += send_len;
    endtask

    // Pick plausible field values, then bend them for channel and align faults
    task automatic queue_random_header(input t_header_fault fault, input int send_len);
        logic [15:0] ch;
        logic [15:0] bits;
        logic [15:0] align;
        logic [31:0] dsize;
        logic [31:0] prod;
        logic [15:0] amask;
        ch = 16'($urandom_range(2, 1));
        case ($urandom_range(7))
            0, 1:    bits = 16'd16;
            2:       bits = 16'd8;
            3:       bits = 16'd24;
            4:       bits = 16'd32;
            5:       bits = 16'($urandom_range(7));   // align can round down to zero
            default: bits = 16'($urandom());
        endcase
        prod = ({16'd0, ch} * {16'd0, bits}) >> 3;
        align = prod[15:0];
        case ($urandom_range(7))
            0:       dsize = 32'd0;
            1:       dsize = 32'hFFFF_FFFF;
            2:       dsize = {16'd0, align} * $urandom_range(5000);
            default: dsize = $urandom();
        endcase
        if (fault == FLT_CHANNELS) begin
            do ch = 16'($urandom());
            while (ch == wavhp_pkg::CH_MONO || ch == wavhp_pkg::CH_STEREO);
        end
        if (fault == FLT_ALIGN) begin
            amask = 16'($urandom());
            if (amask == 16'd0) amask = 16'd1;
            align ^= amask;
        end
        queue_header(fault, ch, bits, align, $urandom(), $urandom(), $urandom(), dsize,
                     send_len, ($urandom_range(3) == 0) ? $urandom_range(4, 1) : 0);
    endtask

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Driver: retire the accepted transaction into the predictor, then offer
    // the next byte unless the sender idles this cycle. Hold while stalled.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_data <= '0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_header_byte(i_data);
                bytes_sent++;
            end
            if (!i_valid || !o_stall) begin
                if (header_bytes_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_valid <= 1'b1;
                    i_data <= header_bytes_q.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
            // Idling plan: sender light / receiver heavy, then swapped, then none
            if (bytes_sent < total_bytes / 3) begin
                send_idle_pct <= 19;
                recv_idle_pct <= 81;
            end else if (bytes_sent < 2 * total_bytes / 3) begin
                send_idle_pct <= 81;
                recv_idle_pct <= 19;
            end else begin
                send_idle_pct <= 0;
                recv_idle_pct <= 0;
            end
        end
    end

    // Monitor: check each accepted result against the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (header_results_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual status %0d",
                             $time, o_data.status);
                    mismatches++;
                end else begin
                    wavhp_pkg::t_out_item want;
                    want = header_results_q.pop_front();
                    report_field("status", 32'(want.status), 32'(o_data.status));
                    report_field("channels", 32'(want.channels), 32'(o_data.channels));
                    report_field("sample_rate", want.sample_rate, o_data.sample_rate);
                    report_field("avg_bytes_sec", want.avg_bytes_sec, o_data.avg_bytes_sec);
                    report_field("block_align", 32'(want.block_align),
                                 32'(o_data.block_align));
                    report_field("sample_bits", 32'(want.sample_bits),
                                 32'(o_data.sample_bits));
                    report_field("riff_size", want.riff_size, o_data.riff_size);
                    report_field("data_size", want.data_size, o_data.data_size);
                    report_field("total_samples", want.total_samples, o_data.total_samples);
                end
            end
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog: give up when neither channel moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        int                  n;
        int unsigned         pick;
        wavhp_pkg::t_in_item it;
        t_header_fault       fault;

        // Hold reset while the stimulus is built
        i_rst_n = 1'b0;

        // Directed: stray bytes before any start must be dropped
        for (int i = 0; i < 3; i++) begin
            it.header_byte = (i == 0) ? 8'h00 : 8'hFF;
            it.start_req = 1'b0;
            header_bytes_q.push_back(it);
        end
        // Clean headers: mono 16-bit, stereo 8-bit with all-ones pass-through fields,
        // align 1 with max data size and all-zero pass-through fields, widest bits field
        queue_header(FLT_NONE, 16'd1, 16'd16, 16'd2, 32'd36036, 32'd44100, 32'd88200,
                     32'd1000, 44, 0);
        queue_header(FLT_NONE, 16'd2, 16'd8, 16'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF, 44, 3);
        queue_header(FLT_NONE, 16'd1, 16'd8, 16'd1, 32'd0, 32'd0, 32'd0,
                     32'hFFFF_FFFF, 44, 0);
        queue_header(FLT_NONE, 16'd2, 16'hFFFF, 16'd16383, 32'd0, 32'd8000, 32'd0,
                     32'hFFFF_FFFF, 44, 0);
        // Zero block align: flagged, no division
        queue_header(FLT_NONE, 16'd1, 16'd4, 16'd0, 32'd100, 32'd8000, 32'd0,
                     32'd5000, 44, 0);
        queue_header(FLT_NONE, 16'd2, 16'd0, 16'd0, 32'd100, 32'd8000, 32'd0,
                     32'd0, 44, 0);
        // Each failing check in header order
        queue_header(FLT_RIFF, 16'd1, 16'd16, 16'd2, 32'd0, 32'd0, 32'd0, 32'd0, 44, 0);
        queue_header(FLT_WAVE, 16'd1, 16'd16, 16'd2, 32'd7, 32'd0, 32'd0, 32'd0, 44, 0);
        queue_header(FLT_FMT_ID, 16'd1, 16'd16, 16'd2, 32'd7, 32'd0, 32'd0, 32'd0, 44, 0);
        queue_header(FLT_FMT_SIZE, 16'd1, 16'd16, 16'd2, 32'd7, 32'd0, 32'd0, 32'd0, 44, 0);
        queue_header(FLT_FORMAT, 16'd1, 16'd16, 16'd2, 32'd7, 32'd0, 32'd0, 32'd0, 44, 0);
        queue_header(FLT_NONE, 16'd0, 16'd16, 16'd0, 32'd7, 32'd0, 32'd0, 32'd0, 44, 0);
        queue_header(FLT_NONE, 16'd3, 16'd16, 16'd6, 32'd7, 32'd0, 32'd0, 32'd0, 44, 0);
        queue_header(FLT_NONE, 16'hFFFF, 16'd16, 16'd2, 32'd7, 32'd0, 32'd0, 32'd0, 44, 2);
        queue_header(FLT_NONE, 16'd2, 16'd16, 16'd3, 32'd7, 32'd48000, 32'd1, 32'd0, 44, 0);
        queue_header(FLT_DATA_ID, 16'd2, 16'd16, 16'd4, 32'd7, 32'd48000, 32'd1,
                     32'd400, 44, 0);
        // A new start abandons a header mid-way, even one byte short of the end
        queue_header(FLT_NONE, 16'd1, 16'd16, 16'd2, 32'd7, 32'd0, 32'd0, 32'd0, 20, 0);
        queue_header(FLT_NONE, 16'd1, 16'd16, 16'd2, 32'd7, 32'd0, 32'd0, 32'd9, 43, 0);
        queue_header(FLT_NONE, 16'd2, 16'd24, 16'd6, 32'd7, 32'd96000, 32'd5, 32'd600,
                     44, 4);

        // Random: mostly well-formed headers, mixed with faults, cut-offs and noise
        while (total_bytes < TARGET_BYTES) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                queue_random_header(FLT_NONE, 44);
            end else if (pick < 75) begin
                fault = t_header_fault'($urandom_range(FLT_DATA_ID, FLT_RIFF));
                queue_random_header(fault, 44);
            end else if (pick < 88) begin
                queue_random_header(FLT_NONE, $urandom_range(43, 1));
            end else begin
                n = $urandom_range(8, 1);
                for (int i = 0; i < n; i++) begin
                    it.header_byte = 8'($urandom_range(255));
                    it.start_req = ($urandom_range(7) == 0);
                    header_bytes_q.push_back(it);
                end
                total_bytes += n;
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for the stream to drain and every predicted result to arrive
        while (header_bytes_q.size() > 0 || i_valid || header_results_q.size() > 0)
            @(posedge i_clk);
        // Leave room for a stray late result to show up
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
